>>> design/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

	// working variables a..h, index 0 is a
	typedef logic [7:0][31:0] vars_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PMARK,
		ST_PZERO,
		ST_PLEN,
		ST_LOAD,
		ST_RA,
		ST_RB,
		ST_RC,
		ST_FIN,
		ST_ADD,
		ST_OUT
	} st_t;

	localparam logic [5:0] POS_LAST = 6'd63;
	localparam logic [5:0] POS_LEN  = 6'd56;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [3:0] SWEEP_END = 4'd8;
	localparam logic [5:0] RND_LAST = 6'd63;

	localparam logic [31:0] HASH_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

>>> design/sha256_ram.sv
`timescale 1ns / 1ps

module sha256_ram #(
	parameter int Width = 32,
	parameter int Depth = 16,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/sha256_rnd.sv
`timescale 1ns / 1ps

module sha256_rnd (
	input  sha256_pkg::vars_t vars,
	input  logic [31:0]       k,
	input  logic [31:0]       w,
	output sha256_pkg::vars_t vars_next
);

	import sha256_pkg::*;

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1  = vars[7] + big_s1(vars[4]) + ch + k + w;
		t2  = big_s0(vars[0]) + maj;
		vars_next[0] = t1 + t2;
		vars_next[1] = vars[0];
		vars_next[2] = vars[1];
		vars_next[3] = vars[2];
		vars_next[4] = vars[3] + t1;
		vars_next[5] = vars[4];
		vars_next[6] = vars[5];
		vars_next[7] = vars[6];
	end

endmodule

>>> design/sha256_hash_core.sv
`timescale 1ns / 1ps
// Byte words are taken one per cycle while a block is filling.
// Each full block then compresses with data_stall high: the chain value is loaded, then each of
// 64 rounds runs RA, RB, RC (four schedule reads on two single-read copies), then FIN and the chain add.
// A message end pads with 0x80, zeros and the length, then gives the eight digest words in
// order, each held while digest_stall is high. arst_n clears control state;
// the chain value reads as the initial hash until the first block of a message is added.
module sha256_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	import sha256_pkg::*;

	st_t         state_q, state_d;
	st_t         ret_q, ret_d;
	logic [5:0]  pos_q;
	logic [63:0] count_q;
	logic [5:0]  rc_q;
	logic [3:0]  idx_q;
	logic [2:0]  idx_m1;
	logic        fresh_q;
	logic        pend_q;
	logic        rp_q;
	logic        digest_valid_q;

	logic [23:0] word_q;
	vars_t       vars_q;
	vars_t       rnd_vars;
	logic [31:0] x2_q, x7_q, w_q, k_q;
	logic [31:0] digest_word_q;
	logic [2:0]  word_index_q;
	logic        last_word_q;

	logic        absorb_en;
	logic [7:0]  absorb_b;
	logic [5:0]  len_sh;
	logic [7:0]  len_b;
	logic        first16;
	logic [31:0] w_new;
	logic        out_issue;
	logic        out_end;

	logic        s_we;
	logic [3:0]  s_waddr;
	logic [31:0] s_wdata;
	logic [3:0]  sa_raddr, sb_raddr;
	logic [31:0] sa_rdata, sb_rdata;

	logic        c_we;
	logic [31:0] c_wdata;
	logic [31:0] c_rdata;
	logic [31:0] chain_old;

	// two copies of the schedule window give two reads a cycle
	sha256_ram #(.Width(32), .Depth(16)) u_sched_a (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (sa_raddr),
		.rdata (sa_rdata)
	);

	sha256_ram #(.Width(32), .Depth(16)) u_sched_b (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (sb_raddr),
		.rdata (sb_rdata)
	);

	sha256_ram #(.Width(32), .Depth(8)) u_chain (
		.clk   (clk),
		.we    (c_we),
		.waddr (idx_m1),
		.wdata (c_wdata),
		.raddr (idx_q[2:0]),
		.rdata (c_rdata)
	);

	sha256_rnd u_rnd (
		.vars      (vars_q),
		.k         (k_q),
		.w         (w_q),
		.vars_next (rnd_vars)
	);

	assign idx_m1  = 3'(idx_q - 4'd1);
	assign len_sh  = {3'd7 - pos_q[2:0], 3'b000};
	assign len_b   = 8'(count_q >> len_sh);
	assign first16 = (rc_q[5:4] == 2'b00);

	assign w_new = first16 ? x2_q
		: small_s1(x2_q) + x7_q + small_s0(sa_rdata) + sb_rdata;

	assign chain_old = fresh_q ? HASH_IV[idx_m1] : c_rdata;
	assign c_we      = (state_q == ST_ADD) && (idx_q != 4'd0);
	assign c_wdata   = chain_old + vars_q[0];

	assign out_issue = (state_q == ST_OUT) && !rp_q && (!digest_valid_q || !digest_stall);
	assign out_end   = (state_q == ST_OUT) && rp_q && (idx_q[2:0] == 3'd7);

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		absorb_en  = 1'b0;
		absorb_b   = 8'h00;
		data_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (data_valid) begin
					absorb_en = has_byte;
					absorb_b  = data_byte;
					if (has_byte && pos_q == POS_LAST) begin
						state_d = ST_LOAD;
						ret_d   = last_byte ? ST_PMARK : ST_IDLE;
					end else if (last_byte) begin
						state_d = ST_PMARK;
					end
				end
			end
			ST_PMARK: begin
				absorb_en = 1'b1;
				absorb_b  = PAD_MARK;
				if (pos_q == POS_LAST) begin
					state_d = ST_LOAD;
					ret_d   = ST_PZERO;
				end else begin
					state_d = ST_PZERO;
				end
			end
			ST_PZERO: begin
				if (pos_q == POS_LEN) begin
					state_d = ST_PLEN;
				end else begin
					absorb_en = 1'b1;
					if (pos_q == POS_LAST) begin
						state_d = ST_LOAD;
						ret_d   = ST_PZERO;
					end
				end
			end
			ST_PLEN: begin
				absorb_en = 1'b1;
				absorb_b  = len_b;
				if (pos_q == POS_LAST) begin
					state_d = ST_LOAD;
					ret_d   = ST_OUT;
				end
			end
			ST_LOAD: begin
				if (idx_q == SWEEP_END) begin
					state_d = ST_RA;
				end
			end
			ST_RA: state_d = ST_RB;
			ST_RB: state_d = ST_RC;
			ST_RC: begin
				state_d = (rc_q == RND_LAST) ? ST_FIN : ST_RA;
			end
			ST_FIN: state_d = ST_ADD;
			ST_ADD: begin
				if (idx_q == SWEEP_END) begin
					state_d = ret_q;
				end
			end
			ST_OUT: begin
				if (out_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// schedule memory access: byte packing while filling, expansion during rounds
	always_comb begin
		sa_raddr = rc_q[3:0];
		sb_raddr = rc_q[3:0];
		case (state_q)
			ST_RA: begin
				sa_raddr = first16 ? rc_q[3:0] : rc_q[3:0] - 4'd2;
				sb_raddr = rc_q[3:0] - 4'd7;
			end
			ST_RB: begin
				sa_raddr = rc_q[3:0] - 4'd15;
				sb_raddr = rc_q[3:0];
			end
			default: begin
				sa_raddr = rc_q[3:0];
				sb_raddr = rc_q[3:0];
			end
		endcase
		if (state_q == ST_RC) begin
			s_we    = 1'b1;
			s_waddr = rc_q[3:0];
			s_wdata = w_new;
		end else begin
			s_we    = absorb_en && (pos_q[1:0] == 2'b11);
			s_waddr = pos_q[5:2];
			s_wdata = {word_q, absorb_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ret_q          <= ST_IDLE;
			pos_q          <= '0;
			count_q        <= '0;
			rc_q           <= '0;
			idx_q          <= '0;
			fresh_q        <= 1'b1;
			pend_q         <= 1'b0;
			rp_q           <= 1'b0;
			digest_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (absorb_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (state_q == ST_IDLE && data_valid && has_byte) begin
				count_q <= count_q + 64'd8;
			end else if (out_end) begin
				count_q <= '0;
			end
			case (state_q)
				ST_LOAD, ST_ADD: idx_q <= (idx_q == SWEEP_END) ? 4'd0 : idx_q + 4'd1;
				ST_OUT: begin
					if (out_end) begin
						idx_q <= '0;
					end else if (rp_q) begin
						idx_q <= idx_q + 4'd1;
					end
				end
				default: idx_q <= idx_q;
			endcase
			if (state_q == ST_LOAD && idx_q == SWEEP_END) begin
				rc_q   <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_RA) begin
				pend_q <= 1'b0;
			end else if (state_q == ST_RC) begin
				rc_q   <= rc_q + 6'd1;
				pend_q <= 1'b1;
			end
			if (state_q == ST_ADD && idx_q == SWEEP_END) begin
				fresh_q <= 1'b0;
			end else if (out_end) begin
				fresh_q <= 1'b1;
			end
			if (out_issue) begin
				rp_q <= 1'b1;
			end else if (rp_q) begin
				rp_q <= 1'b0;
			end
			if (rp_q) begin
				digest_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				digest_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (absorb_en) begin
			word_q <= {word_q[15:0], absorb_b};
		end
		case (state_q)
			ST_LOAD: begin
				if (idx_q != 4'd0) begin
					vars_q <= {chain_old, vars_q[7:1]};
				end
			end
			ST_RA: begin
				if (pend_q) begin
					vars_q <= rnd_vars;
				end
			end
			ST_RB: begin
				x2_q <= sa_rdata;
				x7_q <= sb_rdata;
			end
			ST_RC: begin
				w_q <= w_new;
				k_q <= ROUND_K[rc_q];
			end
			ST_FIN: vars_q <= rnd_vars;
			ST_ADD: begin
				if (idx_q != 4'd0) begin
					vars_q <= {vars_q[0], vars_q[7:1]};
				end
			end
			default: vars_q <= vars_q;
		endcase
		if (rp_q) begin
			digest_word_q <= c_rdata;
			word_index_q  <= idx_q[2:0];
			last_word_q   <= (idx_q[2:0] == 3'd7);
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest_word  = digest_word_q;
	assign word_index   = word_index_q;
	assign last_word    = last_word_q;

	// a block always starts compressing on a block boundary
	a_load_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_LOAD) |-> pos_q == 6'd0)
		else $error("compression started off a block boundary");

	// the digest is read from a chain value that holds real sums
	a_out_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !fresh_q)
		else $error("digest read while chain value still initial");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last word flag and index disagree");

	a_fin_after_64: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> rc_q == 6'd0 && $past(rc_q) == RND_LAST)
		else $error("final round not after round 63");

endmodule
